>>> rtl/ewra_pkg.sv
package ewra_pkg;

	localparam int POS_W   = 13;
	localparam int RATE_W  = 14;
	localparam int COUNT_W = 29;
	localparam int ANGLE_W = 35;
	localparam int TURN_W  = 16;
	localparam int ABASE_W = 30;

	localparam int RATE_DEPTH_DEF = 8;

	localparam logic [POS_W-1:0]          WRAP_RESET      = 13'd7500;
	localparam logic signed [TURN_W-1:0]  TURN_LIMIT      = 16'sd32767;
	localparam logic signed [RATE_W:0]    TURN_STEP       = 15'sd8192;
	localparam logic signed [ANGLE_W-1:0] ANGLE_PER_COUNT = 35'sd45;

	typedef enum logic {
		KIND_CAPTURE = 1'b0,
		KIND_SAMPLE  = 1'b1
	} kind_t;

	typedef struct packed {
		logic signed [RATE_W-1:0]  rate;
		logic signed [COUNT_W-1:0] count;
		logic signed [ABASE_W-1:0] angle_base;
		logic signed [TURN_W-1:0]  turns;
	} unwrap_res_t;

endpackage

>>> rtl/ewra_if.sv
interface ewra_in_if;
	import ewra_pkg::*;

	logic             valid;
	logic             ready;
	logic             kind;
	logic [POS_W-1:0] position;

	modport source (output valid, kind, position, input ready);
	modport sink (input valid, kind, position, output ready);
endinterface

interface ewra_out_if;
	import ewra_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [RATE_W-1:0]  raw_rate;
	logic signed [RATE_W-1:0]  filtered_rate;
	logic signed [COUNT_W-1:0] continuous_count;
	logic signed [ANGLE_W-1:0] angle_q10;
	logic signed [TURN_W-1:0]  turns;

	modport source (
		output valid, raw_rate, filtered_rate, continuous_count, angle_q10, turns,
		input ready
	);
	modport sink (
		input valid, raw_rate, filtered_rate, continuous_count, angle_q10, turns,
		output ready
	);
endinterface

>>> rtl/ewra_unwrap.sv
module ewra_unwrap (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          kind,
	input  logic [ewra_pkg::POS_W-1:0]    position,
	input  logic [ewra_pkg::POS_W-1:0]    wrap_threshold,
	output ewra_pkg::unwrap_res_t         res
);
	import ewra_pkg::*;

	logic [POS_W-1:0]         bias_q;
	logic [POS_W-1:0]         prev_q;
	logic signed [TURN_W-1:0] turns_q;

	logic signed [RATE_W:0]   diff;
	logic signed [RATE_W:0]   thr;
	logic signed [RATE_W:0]   rate_w;
	logic signed [TURN_W-1:0] turns_nx;
	logic                     fwd;
	logic                     bwd;

	always_comb begin
		diff = $signed({2'b00, position}) - $signed({2'b00, prev_q});
		thr  = $signed({2'b00, wrap_threshold});
		fwd  = diff < -thr;
		bwd  = diff > thr;
		rate_w = diff;
		turns_nx = turns_q;
		if (fwd) begin
			rate_w = diff + TURN_STEP;
			if (turns_q != TURN_LIMIT)
				turns_nx = turns_q + 16'sd1;
		end else if (bwd) begin
			rate_w = diff - TURN_STEP;
			if (turns_q != -TURN_LIMIT)
				turns_nx = turns_q - 16'sd1;
		end

		if (kind == KIND_SAMPLE) begin
			res.rate       = rate_w[RATE_W-1:0];
			res.count      = {turns_nx, position};
			res.angle_base = {turns_nx[TURN_W-1], turns_nx, position}
			               - {{(ABASE_W-POS_W){1'b0}}, bias_q};
			res.turns      = turns_nx;
		end else begin
			res.rate       = '0;
			res.count      = {{(COUNT_W-POS_W){1'b0}}, position};
			res.angle_base = '0;
			res.turns      = turns_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q  <= '0;
			prev_q  <= '0;
			turns_q <= '0;
		end else if (step) begin
			prev_q <= position;
			if (kind == KIND_SAMPLE)
				turns_q <= turns_nx;
			else
				bias_q <= position;
		end
	end

endmodule

>>> rtl/ewra_rate_ring.sv
module ewra_rate_ring #(
	parameter int RATE_DEPTH = ewra_pkg::RATE_DEPTH_DEF,
	parameter int SUM_W      = ewra_pkg::RATE_W + $clog2(RATE_DEPTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  logic signed [ewra_pkg::RATE_W-1:0] rate,
	output logic signed [SUM_W-1:0]            sum_nx
);
	import ewra_pkg::*;

	logic signed [RATE_W-1:0] ring_q [RATE_DEPTH];
	logic signed [SUM_W-1:0]  sum_q;

	always_comb begin
		if (push)
			sum_nx = sum_q + SUM_W'(rate) - SUM_W'(ring_q[RATE_DEPTH-1]);
		else
			sum_nx = sum_q;
	end

	// shift line: newest rate at the head, the one leaving the window at the tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			for (int i = 0; i < RATE_DEPTH; i++)
				ring_q[i] <= '0;
		end else if (push) begin
			sum_q     <= sum_nx;
			ring_q[0] <= rate;
			for (int i = 1; i < RATE_DEPTH; i++)
				ring_q[i] <= ring_q[i-1];
		end
	end

endmodule

>>> rtl/ewra_scale.sv
module ewra_scale #(
	parameter int RATE_DEPTH = ewra_pkg::RATE_DEPTH_DEF,
	parameter int SUM_W      = ewra_pkg::RATE_W + $clog2(RATE_DEPTH)
) (
	input  logic signed [SUM_W-1:0]             sum,
	input  logic signed [ewra_pkg::ABASE_W-1:0] angle_base,
	output logic signed [ewra_pkg::RATE_W-1:0]  mean,
	output logic signed [ewra_pkg::ANGLE_W-1:0] angle
);
	import ewra_pkg::*;

	localparam int SHIFT = SUM_W + $clog2(RATE_DEPTH);
	localparam int PROD_W = 2 * SUM_W + 1;
	// reciprocal rounded up, exact for every magnitude below 2**SUM_W
	localparam logic [SUM_W:0] RECIP =
		(SUM_W+1)'(((64'd1 << SHIFT) + 64'(RATE_DEPTH) - 64'd1) / 64'(RATE_DEPTH));

	logic                     neg;
	logic [SUM_W-1:0]         mag;
	logic [PROD_W-1:0]        prod;
	logic [RATE_W-1:0]        quot;
	logic signed [ANGLE_W-1:0] ab_ext;

	always_comb begin
		neg    = sum[SUM_W-1];
		mag    = neg ? SUM_W'(-sum) : SUM_W'(sum);
		prod   = {{(SUM_W+1){1'b0}}, mag} * {{SUM_W{1'b0}}, RECIP};
		quot   = prod[SHIFT +: RATE_W];
		mean   = neg ? -$signed(quot) : $signed(quot);
		ab_ext = ANGLE_W'(angle_base);
		angle  = ab_ext * ANGLE_PER_COUNT;
	end

endmodule

>>> rtl/encoder_unwrap_rate_average_core.sv
// Multi-turn encoder unwrap with moving-average rate.
// sample channel: one item per encoder reading; kind selects capture (position
// becomes bias and previous sample) or sample (position is unwrapped against
// the previous sample, turn count saturates at +/-32767).
// result channel: exactly one item per accepted item, in order, carrying the
// per-sample rate, the mean of the last RATE_DEPTH rates (truncated toward
// zero), the continuous count, the angle from bias in 1/1024 degree and the
// turn count.
// wr_en/wr_data write the wrap threshold; write only while no item is in flight.
// Pipeline: an accepted item is loaded into the input register, then the unwrap
// result and running-sum update are registered, and then the reciprocal multiply
// for the mean and the angle scaling are loaded into the result register.
// Throughput is one item per cycle while the receiver keeps result.ready high.
// When the receiver stalls the stages fill behind the result register and
// sample.ready drops only once all three stages hold items.
// Reset clears the turn count, bias, previous sample, rate window and sum at
// once (no clearing pass) and loads the threshold with 7500.
module encoder_unwrap_rate_average_core #(
	parameter int RATE_DEPTH = ewra_pkg::RATE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [ewra_pkg::POS_W-1:0] wr_data,
	ewra_in_if.sink                    sample,
	ewra_out_if.source                 result
);
	import ewra_pkg::*;

	localparam int SUM_W = RATE_W + $clog2(RATE_DEPTH);

	logic [POS_W-1:0] wrap_threshold_q;

	logic              v_s1, v_s2, v_s3;
	logic              en1, en2, en3;
	logic              step;
	logic              kind_s1;
	logic [POS_W-1:0]  pos_s1;

	unwrap_res_t             unw;
	logic signed [SUM_W-1:0] sum_nx;
	unwrap_res_t             res_s2;
	logic signed [SUM_W-1:0] sum_s2;

	logic signed [RATE_W-1:0]  mean;
	logic signed [ANGLE_W-1:0] angle;

	logic signed [RATE_W-1:0]  rate_s3;
	logic signed [RATE_W-1:0]  mean_s3;
	logic signed [COUNT_W-1:0] count_s3;
	logic signed [ANGLE_W-1:0] angle_s3;
	logic signed [TURN_W-1:0]  turns_s3;

	assign en3  = !v_s3 || result.ready;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;
	assign step = v_s1 && en2;

	assign sample.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wrap_threshold_q <= WRAP_RESET;
		else if (wr_en)
			wrap_threshold_q <= wr_data;
	end

	ewra_unwrap u_unwrap (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.kind           (kind_s1),
		.position       (pos_s1),
		.wrap_threshold (wrap_threshold_q),
		.res            (unw)
	);

	ewra_rate_ring #(
		.RATE_DEPTH (RATE_DEPTH),
		.SUM_W      (SUM_W)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step && kind_s1 == KIND_SAMPLE),
		.rate   (unw.rate),
		.sum_nx (sum_nx)
	);

	ewra_scale #(
		.RATE_DEPTH (RATE_DEPTH),
		.SUM_W      (SUM_W)
	) u_scale (
		.sum        (sum_s2),
		.angle_base (res_s2.angle_base),
		.mean       (mean),
		.angle      (angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= sample.valid;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && sample.valid) begin
			kind_s1 <= sample.kind;
			pos_s1  <= sample.position;
		end
		if (step) begin
			res_s2 <= unw;
			sum_s2 <= sum_nx;
		end
		if (en3 && v_s2) begin
			rate_s3  <= res_s2.rate;
			mean_s3  <= mean;
			count_s3 <= res_s2.count;
			angle_s3 <= angle;
			turns_s3 <= res_s2.turns;
		end
	end

	assign result.valid            = v_s3;
	assign result.raw_rate         = rate_s3;
	assign result.filtered_rate    = mean_s3;
	assign result.continuous_count = count_s3;
	assign result.angle_q10        = angle_s3;
	assign result.turns            = turns_s3;

endmodule

>>> sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ewra_pkg::*;

	localparam int COUNTS_PER_TURN = 8192;
	localparam int POS_MASK        = 8191;
	localparam int TURN_MAX        = 32767;
	localparam int Q10_PER_COUNT   = 45;
	localparam int Q10_PER_TURN    = 368640;

	typedef struct {
		kind_t            kind;
		logic [POS_W-1:0] position;
	} item_t;

	typedef struct packed {
		logic signed [RATE_W-1:0]  raw_rate;
		logic signed [RATE_W-1:0]  filtered_rate;
		logic signed [COUNT_W-1:0] continuous_count;
		logic signed [ANGLE_W-1:0] angle_q10;
		logic signed [TURN_W-1:0]  turns;
	} reading_t;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic [POS_W-1:0] wr_data;

	ewra_in_if  sample_if ();
	ewra_out_if result_if ();

	encoder_unwrap_rate_average_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.sample  (sample_if),
		.result  (result_if)
	);

	// predictor state
	int wrap_thr;
	int bias_pos;
	int prev_pos;
	int turn_cnt;
	int rate_ring [RATE_DEPTH_DEF];
	int ring_ptr;
	int rate_sum;
	int turn_lo;
	int turn_hi;

	item_t    positions_pending [$];
	reading_t readings_due [$];
	item_t    nxt;
	reading_t want;

	int walk_pos;
	int idle_pct;
	int src_gap;
	int snk_stall;
	int mismatches;
	int checked;
	int items_sent;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic reading_t unwrap_predict(input kind_t kind, input logic [POS_W-1:0] pos);
		reading_t r;
		int p;
		int step;
		int rate;
		int cnt;
		longint ang;
		p = int'(pos);
		rate = 0;
		cnt = p;
		ang = 0;
		if (kind == KIND_CAPTURE) begin
			bias_pos = p;
			prev_pos = p;
		end else begin
			step = p - prev_pos;
			prev_pos = p;
			if (step < -wrap_thr) begin
				if (turn_cnt < TURN_MAX)
					turn_cnt++;
				rate = step + COUNTS_PER_TURN;
			end else if (step > wrap_thr) begin
				if (turn_cnt > -TURN_MAX)
					turn_cnt--;
				rate = step - COUNTS_PER_TURN;
			end else begin
				rate = step;
			end
			cnt = p + turn_cnt * COUNTS_PER_TURN;
			ang = longint'(p - bias_pos) * Q10_PER_COUNT + longint'(turn_cnt) * Q10_PER_TURN;
			rate_sum += rate - rate_ring[ring_ptr];
			rate_ring[ring_ptr] = rate;
			ring_ptr = (ring_ptr + 1) % RATE_DEPTH_DEF;
		end
		if (turn_cnt < turn_lo)
			turn_lo = turn_cnt;
		if (turn_cnt > turn_hi)
			turn_hi = turn_cnt;
		r.raw_rate         = RATE_W'(rate);
		r.filtered_rate    = RATE_W'(rate_sum / RATE_DEPTH_DEF);
		r.continuous_count = COUNT_W'(cnt);
		r.angle_q10        = ANGLE_W'(ang);
		r.turns            = TURN_W'(turn_cnt);
		return r;
	endfunction

	task automatic report(input string field, input longint exp_v, input longint got_v);
		mismatches++;
		$error("%s expected %0d got %0d", field, exp_v, got_v);
	endtask

	task automatic push_item(input kind_t kind, input int pos);
		item_t it;
		walk_pos = pos & POS_MASK;
		it.kind = kind;
		it.position = POS_W'(walk_pos);
		positions_pending.push_back(it);
	endtask

	// mostly small moves, with jumps, threshold edges and the ends of the range
	task automatic queue_walk(input int n);
		int step;
		int pos;
		kind_t kind;
		for (int i = 0; i < n; i++) begin
			pos = walk_pos;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: pos = pos + int'($urandom_range(0, 400)) - 200;
				5: pos = $urandom_range(0, POS_MASK);
				6: begin
					step = wrap_thr + int'($urandom_range(0, 1));
					if (pos + step <= POS_MASK && (pos - step < 0 || $urandom_range(0, 1)))
						pos = pos + step;
					else if (pos - step >= 0)
						pos = pos - step;
					else
						pos = $urandom_range(0, POS_MASK);
				end
				7: pos = $urandom_range(0, 1) ? POS_MASK : 0;
				default: pos = pos + int'($urandom_range(0, 8000)) - 4000;
			endcase
			kind = ($urandom_range(0, 11) == 0) ? KIND_CAPTURE : KIND_SAMPLE;
			push_item(kind, pos);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (positions_pending.size() != 0 || sample_if.valid || readings_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_threshold(input int thr);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_data <= POS_W'(thr);
		wrap_thr = thr;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
			sample_if.kind <= KIND_CAPTURE;
			sample_if.position <= '0;
			src_gap = 0;
		end else begin
			if (sample_if.valid && sample_if.ready) begin
				readings_due.push_back(unwrap_predict(kind_t'(sample_if.kind),
					sample_if.position));
				items_sent++;
			end
			if (!(sample_if.valid && !sample_if.ready)) begin
				if (src_gap > 0) begin
					src_gap--;
					sample_if.valid <= 1'b0;
				end else if (positions_pending.size() != 0) begin
					nxt = positions_pending.pop_front();
					sample_if.valid <= 1'b1;
					sample_if.kind <= nxt.kind;
					sample_if.position <= nxt.position;
					if (int'($urandom_range(0, 99)) < idle_pct)
						src_gap = $urandom_range(1, 17);
				end else begin
					sample_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			snk_stall = 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (readings_due.size() == 0) begin
					mismatches++;
					$error("result item arrived with nothing expected");
				end else begin
					want = readings_due.pop_front();
					checked++;
					if (result_if.raw_rate !== want.raw_rate)
						report("raw_rate", want.raw_rate, result_if.raw_rate);
					if (result_if.filtered_rate !== want.filtered_rate)
						report("filtered_rate", want.filtered_rate, result_if.filtered_rate);
					if (result_if.continuous_count !== want.continuous_count)
						report("continuous_count", want.continuous_count,
							result_if.continuous_count);
					if (result_if.angle_q10 !== want.angle_q10)
						report("angle_q10", want.angle_q10, result_if.angle_q10);
					if (result_if.turns !== want.turns)
						report("turns", want.turns, result_if.turns);
				end
			end
			if (snk_stall > 0) begin
				snk_stall--;
				result_if.ready <= 1'b0;
			end else if (int'($urandom_range(0, 99)) < idle_pct) begin
				snk_stall = $urandom_range(1, 17) - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_data = '0;
		sample_if.valid = 1'b0;
		sample_if.kind = KIND_CAPTURE;
		sample_if.position = '0;
		result_if.ready = 1'b0;
		wrap_thr = int'(WRAP_RESET);
		bias_pos = 0;
		prev_pos = 0;
		turn_cnt = 0;
		foreach (rate_ring[i])
			rate_ring[i] = 0;
		ring_ptr = 0;
		rate_sum = 0;
		turn_lo = 0;
		turn_hi = 0;
		walk_pos = 0;
		idle_pct = 0;
		mismatches = 0;
		checked = 0;
		items_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset threshold: wraps at the ends, steps right at and just past the threshold
		idle_pct = 20;
		push_item(KIND_SAMPLE, 0);
		push_item(KIND_CAPTURE, 8191);
		push_item(KIND_SAMPLE, 0);
		push_item(KIND_SAMPLE, 8191);
		push_item(KIND_SAMPLE, 691);
		push_item(KIND_SAMPLE, 8191);
		push_item(KIND_SAMPLE, 690);
		push_item(KIND_SAMPLE, 8191);
		push_item(KIND_CAPTURE, 0);
		push_item(KIND_SAMPLE, 4096);
		push_item(KIND_SAMPLE, 0);
		push_item(KIND_SAMPLE, 8191);
		push_item(KIND_SAMPLE, 0);
		wait_drained();

		set_threshold(1);
		idle_pct = 30;
		push_item(KIND_SAMPLE, 1);
		push_item(KIND_SAMPLE, 3);
		push_item(KIND_SAMPLE, 2);
		push_item(KIND_SAMPLE, 0);
		queue_walk(90);
		wait_drained();

		set_threshold(8191);
		idle_pct = 0;
		push_item(KIND_SAMPLE, 0);
		push_item(KIND_SAMPLE, 8191);
		push_item(KIND_SAMPLE, 0);
		queue_walk(80);
		wait_drained();

		// zero threshold: every move counts as a wrap
		set_threshold(0);
		idle_pct = 15;
		push_item(KIND_SAMPLE, 5);
		push_item(KIND_SAMPLE, 5);
		push_item(KIND_SAMPLE, 4);
		queue_walk(60);
		wait_drained();

		set_threshold($urandom_range(2, 8190));
		idle_pct = 40;
		queue_walk(90);
		wait_drained();

		// zero threshold: walk the turn count one way and then back past its starting value
		set_threshold(0);
		idle_pct = 2;
		push_item(KIND_CAPTURE, 4000);
		for (int i = 0; i < 12; i++)
			push_item(KIND_SAMPLE, walk_pos - 1);
		for (int i = 0; i < 24; i++)
			push_item(KIND_SAMPLE, walk_pos + 1);
		wait_drained();

		set_threshold(int'(WRAP_RESET));
		idle_pct = 0;
		queue_walk(80);
		wait_drained();
		repeat (8) @(posedge clk);

		$display("%0d result items checked against %0d items sent, thresholds 0 to 8191",
			checked, items_sent);
		$display("turn count ranged from %0d to %0d", turn_lo, turn_hi);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> encoder_unwrap_rate_average_core.f
rtl/ewra_pkg.sv
rtl/ewra_if.sv
rtl/ewra_unwrap.sv
rtl/ewra_rate_ring.sv
rtl/ewra_scale.sv
rtl/encoder_unwrap_rate_average_core.sv
sim/testbench.sv
